/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define SSCAM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// clocked assertion, also checked during reset
`define SSCAM_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

/* rtl/core/sscam_pkg.sv */
// ----------------------------------------------------------------------------
// sscam_pkg
// shared widths, codes and transaction types of the speller score unit
// ----------------------------------------------------------------------------
package sscam_pkg;

   localparam int STIM_W      = 5;
   localparam int SCORE_W     = 24;
   localparam int SUM_W       = 32;
   localparam int IDX_W       = 4;
   localparam int DIM_W       = 5;
   localparam int SYM_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 2'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd6;
   localparam logic [DIM_W-1:0] DIM_MIN   = 5'd1;
   localparam logic [DIM_W-1:0] DIM_MAX   = 5'd16;

   // skip: outside the sum store, acc: summed only, col/row: summed and compared
   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_ACC,
      KIND_COL,
      KIND_ROW
   } kind_type;

   typedef struct packed {
      logic [STIM_W-1:0]         stimulus;
      logic signed [SCORE_W-1:0] score;
      logic                      new_letter;
      logic                      last_of_sequence;
      logic [IDX_W-1:0]          target_col;
      logic [IDX_W-1:0]          target_row;
      kind_type                  kind;
      logic [IDX_W-1:0]          local_index;
      logic [DIM_W-1:0]          cols;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] pred_col;
      logic [IDX_W-1:0] pred_row;
      logic [SYM_W-1:0] symbol_index;
      logic             hit;
   } result_type;

endpackage

/* rtl/core/sscam_fifo.sv */
// ----------------------------------------------------------------------------
// sscam_fifo
// short register queue decoupling two pipeline sections
// ----------------------------------------------------------------------------
module sscam_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  T                             push_data,
   output logic                         full,
   input  logic                         pop,
   output T                             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   T                store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/sscam_front.sv */
// ----------------------------------------------------------------------------
// sscam_front
// configuration registers and classification of incoming score transactions
// ----------------------------------------------------------------------------
module sscam_front #(
   parameter int MAX_STIMULI = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sscam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sscam_pkg::DIM_W-1:0]          csr_data,
   input  logic                                 req_push,
   input  logic [sscam_pkg::STIM_W-1:0]         req_stimulus,
   input  logic signed [sscam_pkg::SCORE_W-1:0] req_score,
   input  logic                                 req_new_letter,
   input  logic                                 req_last_of_sequence,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_col,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_row,
   input  logic                                 mid_full,
   output logic                                 mid_push,
   output sscam_pkg::item_type                  mid_item
);

   import sscam_pkg::*;

   logic [DIM_W-1:0] num_cols_ff, num_cols_in;
   logic [DIM_W-1:0] num_rows_ff, num_rows_in;
   logic [DIM_W-1:0] cols, rows;
   logic [DIM_W:0]   span;
   logic             in_store;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      num_cols_in = num_cols_ff;
      num_rows_in = num_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_NUM_COLS: num_cols_in = csr_data;
            REG_NUM_ROWS: num_rows_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= DIM_RESET;
         num_rows_ff <= DIM_RESET;
      end else begin
         num_cols_ff <= num_cols_in;
         num_rows_ff <= num_rows_in;
      end
   end

   assign cols     = clamp_dim(num_cols_ff);
   assign rows     = clamp_dim(num_rows_ff);
   assign span     = {1'b0, cols} + {1'b0, rows};
   assign in_store = int'(req_stimulus) < MAX_STIMULI;
   assign mid_push = req_push && !mid_full;

   always_comb begin
      mid_item.stimulus         = req_stimulus;
      mid_item.score            = req_score;
      mid_item.new_letter       = req_new_letter;
      mid_item.last_of_sequence = req_last_of_sequence;
      mid_item.target_col       = req_target_col;
      mid_item.target_row       = req_target_row;
      mid_item.cols             = cols;
      mid_item.kind             = KIND_SKIP;
      mid_item.local_index      = '0;
      if (in_store) begin
         if (req_stimulus < cols) begin
            mid_item.kind        = KIND_COL;
            mid_item.local_index = IDX_W'(req_stimulus);
         end else if ({1'b0, req_stimulus} < span) begin
            mid_item.kind        = KIND_ROW;
            mid_item.local_index = IDX_W'(req_stimulus - cols);
         end else begin
            mid_item.kind = KIND_ACC;
         end
      end
   end

endmodule

/* rtl/core/sscam_back.sv */
// ----------------------------------------------------------------------------
// sscam_back
// sum store read-modify-write, running column and row maxima, result build
// ----------------------------------------------------------------------------
module sscam_back #(
   parameter int MAX_STIMULI = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sscam_pkg::item_type              mid_item,
   input  logic                             mid_empty,
   output logic                             mid_pop,
   input  logic [sscam_pkg::QCNT_W-1:0]     out_count,
   output logic                             res_push,
   output sscam_pkg::result_type            res_data
);

   import sscam_pkg::*;

   localparam int AW = (MAX_STIMULI > 1) ? $clog2(MAX_STIMULI) : 1;
   localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

   logic signed [SUM_W-1:0] sums_mem [MAX_STIMULI];
   logic [MAX_STIMULI-1:0]  written_ff;

   logic                    issue;
   logic [AW-1:0]           rd_addr;
   logic signed [SUM_W-1:0] rd_data_ff;
   logic                    rd_written_ff;
   item_type                b_item_ff;
   logic                    b_valid_ff;
   logic [AW-1:0]           b_addr_ff;

   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic signed [SUM_W-1:0] fwd_data_ff;

   logic signed [SUM_W-1:0] best_col_sum_ff, best_col_sum_in;
   logic signed [SUM_W-1:0] best_row_sum_ff, best_row_sum_in;
   logic [IDX_W-1:0]        best_col_index_ff, best_col_index_in;
   logic [IDX_W-1:0]        best_row_index_ff, best_row_index_in;
   logic                    col_seen_ff, col_seen_in;
   logic                    row_seen_ff, row_seen_in;

   logic signed [SUM_W-1:0] old_sum, new_sum;
   logic [SUM_W:0]          wide_sum;
   logic                    wr_en;
   logic [8:0]              sym_wide;

   // room in the result queue for anything still in flight
   assign issue   = !mid_empty &&
                    ((int'(out_count) + int'(b_valid_ff)) < QUEUE_DEPTH);
   assign mid_pop = issue;
   assign rd_addr = AW'(mid_item.stimulus);

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff    <= sums_mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
         b_item_ff     <= mid_item;
         b_addr_ff     <= rd_addr;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) begin
         old_sum = fwd_data_ff;
      end else if (rd_written_ff) begin
         old_sum = rd_data_ff;
      end else begin
         old_sum = '0;
      end
      wide_sum = {old_sum[SUM_W-1], old_sum} + (SUM_W+1)'(b_item_ff.score);
      if (b_item_ff.new_letter) begin
         new_sum = SUM_W'(b_item_ff.score);
      end else if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
         new_sum = wide_sum[SUM_W] ? SUM_LO : SUM_HI;
      end else begin
         new_sum = wide_sum[SUM_W-1:0];
      end
   end

   assign wr_en = b_valid_ff && (b_item_ff.kind != KIND_SKIP);

   always_comb begin
      best_col_sum_in   = best_col_sum_ff;
      best_row_sum_in   = best_row_sum_ff;
      best_col_index_in = best_col_index_ff;
      best_row_index_in = best_row_index_ff;
      col_seen_in       = col_seen_ff;
      row_seen_in       = row_seen_ff;
      if (b_valid_ff) begin
         case (b_item_ff.kind)
            KIND_COL: begin
               if (!col_seen_ff || (new_sum > best_col_sum_ff)) begin
                  best_col_sum_in   = new_sum;
                  best_col_index_in = b_item_ff.local_index;
                  col_seen_in       = 1'b1;
               end
            end
            KIND_ROW: begin
               if (!row_seen_ff || (new_sum > best_row_sum_ff)) begin
                  best_row_sum_in   = new_sum;
                  best_row_index_in = b_item_ff.local_index;
                  row_seen_in       = 1'b1;
               end
            end
            default: ;
         endcase
      end

      sym_wide = {5'b0, best_row_index_in} * {4'b0, b_item_ff.cols}
               + {5'b0, best_col_index_in};
      res_data.pred_col     = best_col_index_in;
      res_data.pred_row     = best_row_index_in;
      res_data.symbol_index = sym_wide[SYM_W-1:0];
      res_data.hit          = (best_col_index_in == b_item_ff.target_col) &&
                              (best_row_index_in == b_item_ff.target_row);

      // end of sequence: maxima start over
      if (b_valid_ff && b_item_ff.last_of_sequence) begin
         best_col_sum_in   = '0;
         best_row_sum_in   = '0;
         best_col_index_in = '0;
         best_row_index_in = '0;
         col_seen_in       = 1'b0;
         row_seen_in       = 1'b0;
      end
   end

   assign res_push = b_valid_ff && b_item_ff.last_of_sequence;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff        <= 1'b0;
         fwd_valid_ff      <= 1'b0;
         written_ff        <= '0;
         best_col_sum_ff   <= '0;
         best_row_sum_ff   <= '0;
         best_col_index_ff <= '0;
         best_row_index_ff <= '0;
         col_seen_ff       <= 1'b0;
         row_seen_ff       <= 1'b0;
      end else begin
         b_valid_ff        <= issue;
         fwd_valid_ff      <= wr_en;
         if (wr_en) begin
            written_ff[b_addr_ff] <= 1'b1;
         end
         best_col_sum_ff   <= best_col_sum_in;
         best_row_sum_ff   <= best_row_sum_in;
         best_col_index_ff <= best_col_index_in;
         best_row_index_ff <= best_row_index_in;
         col_seen_ff       <= col_seen_in;
         row_seen_ff       <= row_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= b_addr_ff;
      fwd_data_ff <= new_sum;
      if (wr_en) begin
         sums_mem[b_addr_ff] <= new_sum;
      end
   end

endmodule

/* rtl/core/speller_score_accumulate_argmax_unit.sv */
// ----------------------------------------------------------------------------
// speller_score_accumulate_argmax_unit
// per-stimulus score sums with column and row argmax per sequence
// ----------------------------------------------------------------------------
// Score transactions enter on the req_ queue port: an item is taken when
// req_push is high and req_full is low. One item can be taken every cycle while req_full stays low.
// Each item updates the saturating sum of its stimulus and the running
// column and row maxima; an item with last_of_sequence set yields one
// result on the rsp_ queue port, present while rsp_empty is low and
// taken with rsp_pop.
// From accept to a visible result, the classified item leaves the 4-entry
// middle queue and the sum store is read (registered read); then the add,
// compare and result build run and the result enters the result queue,
// with a forwarding path for back-to-back hits on the same stimulus.
// Sustained throughput is one item per cycle while the result queue has room,
// the sum store read-modify-write using a separate read and write port.
// Reset clears the sums at once through per-entry written flags, restores
// num_cols and num_rows to 6 and leaves both queues empty; no clearing
// pass is needed. When the receiver stalls, the 4-entry result queue
// fills, the back end holds, the middle queue fills and req_full rises.
// Registers num_cols and num_rows are written through csr_, always ready.
// ----------------------------------------------------------------------------
module speller_score_accumulate_argmax_unit #(
   parameter int MAX_STIMULI = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [sscam_pkg::STIM_W-1:0]         req_stimulus,
   input  logic signed [sscam_pkg::SCORE_W-1:0] req_score,
   input  logic                                 req_new_letter,
   input  logic                                 req_last_of_sequence,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_col,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_row,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [sscam_pkg::IDX_W-1:0]          rsp_pred_col,
   output logic [sscam_pkg::IDX_W-1:0]          rsp_pred_row,
   output logic [sscam_pkg::SYM_W-1:0]          rsp_symbol_index,
   output logic                                 rsp_hit,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sscam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sscam_pkg::DIM_W-1:0]          csr_data
);

   import sscam_pkg::*;

   item_type          mid_in_item, mid_out_item;
   logic              mid_push, mid_full, mid_pop, mid_empty;
   result_type        res_data, rsp_data;
   logic              res_push;
   logic [QCNT_W-1:0] out_count;

   assign req_full = mid_full;

   sscam_front #(
      .MAX_STIMULI (MAX_STIMULI)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_push             (req_push),
      .req_stimulus         (req_stimulus),
      .req_score            (req_score),
      .req_new_letter       (req_new_letter),
      .req_last_of_sequence (req_last_of_sequence),
      .req_target_col       (req_target_col),
      .req_target_row       (req_target_row),
      .mid_full             (mid_full),
      .mid_push             (mid_push),
      .mid_item             (mid_in_item)
   );

   sscam_fifo #(
      .T     (item_type),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_item),
      .empty     (mid_empty),
      .count     ()
   );

   sscam_back #(
      .MAX_STIMULI (MAX_STIMULI)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_out_item),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   sscam_fifo #(
      .T     (result_type),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_pred_col     = rsp_data.pred_col;
   assign rsp_pred_row     = rsp_data.pred_row;
   assign rsp_symbol_index = rsp_data.symbol_index;
   assign rsp_hit          = rsp_data.hit;

endmodule

/* rtl/core/sscam_checker.sv */
// ----------------------------------------------------------------------------
// sscam_checker
// port-level checks of the speller score unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sscam_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [3:0]  rsp_pred_col,
   input logic [3:0]  rsp_pred_row,
   input logic [7:0]  rsp_symbol_index,
   input logic        rsp_hit,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic        rsp_held;
   logic [16:0] rsp_bundle;

   // result waiting and not taken
   assign rsp_held   = !rsp_empty && !rsp_pop;
   assign rsp_bundle = {rsp_pred_col, rsp_pred_row, rsp_symbol_index, rsp_hit};

   `SSCAM_ASSERT_NR(a_reset_empty, clock, reset |=> rsp_empty)
   `SSCAM_ASSERT_NR(a_reset_not_full, clock, reset |=> !req_full)
   `SSCAM_ASSERT(a_csr_always_ready, clock, reset, csr_valid |-> csr_ready)
   `SSCAM_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> (!rsp_empty && $stable(rsp_bundle)))

endmodule

bind speller_score_accumulate_argmax_unit sscam_checker u_checker (.*);

/* dv/sscam_argmax_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sscam_argmax_checker
// predicts the letter results of the speller score unit and compares them
// ----------------------------------------------------------------------------
// Watches the req_, rsp_ and csr_ channels. Keeps its own per-stimulus sums,
// sequence maxima and matrix size. Every accepted transaction that closes a
// sequence queues one predicted result. Each popped result is compared field
// by field with the oldest prediction. Mismatch and pending counts go to the
// testbench top.
// ----------------------------------------------------------------------------
module sscam_argmax_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic [sscam_pkg::STIM_W-1:0]         req_stimulus,
   input  logic signed [sscam_pkg::SCORE_W-1:0] req_score,
   input  logic                                 req_new_letter,
   input  logic                                 req_last_of_sequence,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_col,
   input  logic [sscam_pkg::IDX_W-1:0]          req_target_row,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic [sscam_pkg::IDX_W-1:0]          rsp_pred_col,
   input  logic [sscam_pkg::IDX_W-1:0]          rsp_pred_row,
   input  logic [sscam_pkg::SYM_W-1:0]          rsp_symbol_index,
   input  logic                                 rsp_hit,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [sscam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sscam_pkg::DIM_W-1:0]          csr_data,
   output int                                   mismatch_count,
   output int                                   pending_results
);

   import sscam_pkg::*;

   localparam int NUM_STIM = 1 << STIM_W;

   logic signed [SUM_W-1:0] stim_sums [NUM_STIM];
   logic signed [SUM_W-1:0] top_col_sum;
   logic signed [SUM_W-1:0] top_row_sum;
   logic [IDX_W-1:0]        top_col_idx;
   logic [IDX_W-1:0]        top_row_idx;
   logic                    col_found;
   logic                    row_found;
   logic [DIM_W-1:0]        cfg_cols;
   logic [DIM_W-1:0]        cfg_rows;
   result_type              predicted_q [$];
   int                      errors;

   function automatic int matrix_dim(logic [DIM_W-1:0] raw);
      if (raw < DIM_MIN) return int'(DIM_MIN);
      if (raw > DIM_MAX) return int'(DIM_MAX);
      return int'(raw);
   endfunction

   task automatic note_failure(string msg);
      if (errors < 10) $display("%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic accumulate_and_rank(
      logic [STIM_W-1:0]         stim,
      logic signed [SCORE_W-1:0] score,
      logic                      new_letter,
      logic                      last,
      logic [IDX_W-1:0]          target_col,
      logic [IDX_W-1:0]          target_row
   );
      logic signed [SUM_W:0]   wide;
      logic signed [SUM_W-1:0] s;
      int                      cols;
      int                      rows;
      int                      row_off;
      int                      sym;
      result_type              r;
      cols = matrix_dim(cfg_cols);
      rows = matrix_dim(cfg_rows);
      if (new_letter) begin
         s = SUM_W'(score);
      end else begin
         wide = (SUM_W+1)'(stim_sums[stim]) + (SUM_W+1)'(score);
         // clamp to the signed 32-bit range
         if (wide[SUM_W] != wide[SUM_W-1]) begin
            s = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            s = wide[SUM_W-1:0];
         end
      end
      stim_sums[stim] = s;
      if (int'(stim) < cols) begin
         if (!col_found || s > top_col_sum) begin
            top_col_sum = s;
            top_col_idx = stim[IDX_W-1:0];
            col_found   = 1'b1;
         end
      end else if (int'(stim) < cols + rows) begin
         if (!row_found || s > top_row_sum) begin
            row_off     = int'(stim) - cols;
            top_row_sum = s;
            top_row_idx = row_off[IDX_W-1:0];
            row_found   = 1'b1;
         end
      end
      if (last) begin
         sym            = int'(top_row_idx) * cols + int'(top_col_idx);
         r.pred_col     = top_col_idx;
         r.pred_row     = top_row_idx;
         r.symbol_index = sym[SYM_W-1:0];
         r.hit          = (top_col_idx == target_col) && (top_row_idx == target_row);
         predicted_q    = {predicted_q, r};
         col_found   = 1'b0;
         row_found   = 1'b0;
         top_col_idx = '0;
         top_row_idx = '0;
         top_col_sum = '0;
         top_row_sum = '0;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         foreach (stim_sums[i]) stim_sums[i] = '0;
         top_col_sum = '0;
         top_row_sum = '0;
         top_col_idx = '0;
         top_row_idx = '0;
         col_found   = 1'b0;
         row_found   = 1'b0;
         cfg_cols    = DIM_RESET;
         cfg_rows    = DIM_RESET;
         predicted_q.delete();
         errors      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NUM_COLS: cfg_cols = csr_data;
               REG_NUM_ROWS: cfg_rows = csr_data;
               default: ;
            endcase
         end
         if (!rsp_empty && rsp_pop) begin
            if (predicted_q.size() == 0) begin
               note_failure("result transaction with no prediction waiting");
            end else begin
               want = predicted_q.pop_front();
               if (rsp_pred_col !== want.pred_col)
                  note_failure($sformatf("pred_col expected %0d, actual %0d",
                                         want.pred_col, rsp_pred_col));
               if (rsp_pred_row !== want.pred_row)
                  note_failure($sformatf("pred_row expected %0d, actual %0d",
                                         want.pred_row, rsp_pred_row));
               if (rsp_symbol_index !== want.symbol_index)
                  note_failure($sformatf("symbol_index expected %0d, actual %0d",
                                         want.symbol_index, rsp_symbol_index));
               if (rsp_hit !== want.hit)
                  note_failure($sformatf("hit expected %0d, actual %0d",
                                         want.hit, rsp_hit));
            end
         end
         if (req_push && !req_full) begin
            accumulate_and_rank(req_stimulus, req_score, req_new_letter,
                                req_last_of_sequence, req_target_col, req_target_row);
         end
      end
      mismatch_count  <= errors;
      pending_results <= predicted_q.size();
   end

endmodule

/* dv/tb_speller_score_accumulate_argmax_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speller_score_accumulate_argmax_unit
// stimulus and verdict for the speller score accumulate and argmax unit
// ----------------------------------------------------------------------------
// Drives a few hand-picked sequences (ties, carried sums, sequences without
// rows or columns, a stimulus outside the matrix), then random letters over
// several matrix sizes including out-of-range register values, with two
// saturation runs. Sender and receiver stall at random. The checker beside
// the block predicts and compares; the top reports the outcome.
// ----------------------------------------------------------------------------
module tb_speller_score_accumulate_argmax_unit;
   import sscam_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 12;
   localparam int SAT_ITEMS     = 260;
   localparam int SAT_SEQ       = 65;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   logic                      clock                = 1'b0;
   logic                      reset                = 1'b1;
   logic                      req_push             = 1'b0;
   logic                      req_full;
   logic [STIM_W-1:0]         req_stimulus         = '0;
   logic signed [SCORE_W-1:0] req_score            = '0;
   logic                      req_new_letter       = 1'b0;
   logic                      req_last_of_sequence = 1'b0;
   logic [IDX_W-1:0]          req_target_col       = '0;
   logic [IDX_W-1:0]          req_target_row       = '0;
   logic                      rsp_empty;
   logic                      rsp_pop              = 1'b0;
   logic [IDX_W-1:0]          rsp_pred_col;
   logic [IDX_W-1:0]          rsp_pred_row;
   logic [SYM_W-1:0]          rsp_symbol_index;
   logic                      rsp_hit;
   logic                      csr_valid            = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index            = '0;
   logic [DIM_W-1:0]          csr_data             = '0;

   int mismatch_count;
   int pending_results;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int pop_hold  = 0;
   int items_sent = 0;
   int n_cols = 6;
   int n_rows = 6;

   always #2 clock = ~clock;

   speller_score_accumulate_argmax_unit i_dut (.*);

   sscam_argmax_checker i_checker (.*);

   // receiver: random stall before each pop, none in steady phases
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (rsp_pop) begin
         if (!rsp_empty && !rx_steady) begin
            hold = $urandom_range(0, 5);
            if (hold > 0) begin
               rsp_pop  <= 1'b0;
               pop_hold <= hold - 1;
            end
         end
      end else if (pop_hold == 0) begin
         rsp_pop <= 1'b1;
      end else begin
         pop_hold <= pop_hold - 1;
      end
   end

   task automatic send_item(
      logic [STIM_W-1:0]         stim,
      logic signed [SCORE_W-1:0] score,
      logic                      new_letter,
      logic                      last,
      logic [IDX_W-1:0]          target_col,
      logic [IDX_W-1:0]          target_row
   );
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_stimulus         <= stim;
      req_score            <= score;
      req_new_letter       <= new_letter;
      req_last_of_sequence <= last;
      req_target_col       <= target_col;
      req_target_row       <= target_row;
      req_push             <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_matrix(int raw_cols, int raw_rows);
      wait_idle();
      write_reg(REG_NUM_COLS, DIM_W'(raw_cols));
      write_reg(REG_NUM_ROWS, DIM_W'(raw_rows));
      n_cols = (raw_cols == 0) ? 1 : (raw_cols > 16) ? 16 : raw_cols;
      n_rows = (raw_rows == 0) ? 1 : (raw_rows > 16) ? 16 : raw_rows;
   endtask

   function automatic logic signed [SCORE_W-1:0] draw_score(int mode);
      case (mode)
         0: return SCORE_W'($urandom);
         1: return SCORE_W'(int'($urandom_range(0, 64)) - 32);
         2: return SCORE_W'($urandom_range(0, 3) << 16);
         default: return ($urandom_range(0, 1) != 0) ? SCORE_MAX : SCORE_MIN;
      endcase
   endfunction

   task automatic send_letter();
      int                        seqs;
      int                        mode;
      int                        span;
      int                        cnt;
      bit                        boost;
      logic [IDX_W-1:0]          tc;
      logic [IDX_W-1:0]          tr;
      logic signed [SCORE_W-1:0] sc;
      span = n_cols + n_rows;
      if ($urandom_range(0, 7) == 0) begin
         tc = IDX_W'($urandom);
         tr = IDX_W'($urandom);
      end else begin
         tc = IDX_W'($urandom_range(0, n_cols - 1));
         tr = IDX_W'($urandom_range(0, n_rows - 1));
      end
      boost = 1'($urandom_range(0, 1));
      seqs  = $urandom_range(1, 4);
      for (int q = 0; q < seqs; q++) begin
         mode = $urandom_range(0, 3);
         if ($urandom_range(0, 9) < 8) begin
            for (int s = 0; s < span; s++) begin
               sc = draw_score(mode);
               // push the target stimuli up so hits happen
               if (boost && (s == tc || s == n_cols + tr))
                  sc = SCORE_W'($urandom_range(24'h400000, 24'h7fffff));
               send_item(STIM_W'(s), sc, q == 0, s == span - 1, tc, tr);
            end
         end else begin
            cnt = $urandom_range(1, span + 3);
            for (int k = 0; k < cnt; k++)
               send_item(STIM_W'($urandom), draw_score(mode), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0, tc, tr);
         end
      end
   endtask

   task automatic sat_burst(bit up);
      logic [STIM_W-1:0] stim;
      stim = STIM_W'($urandom_range(0, n_cols - 1));
      for (int k = 0; k < SAT_ITEMS; k++)
         send_item(stim, up ? SCORE_MAX : SCORE_MIN, k == 0, k % SAT_SEQ == SAT_SEQ - 1,
                   stim[IDX_W-1:0], '0);
   endtask

   initial begin
      int raw_cols [PHASES];
      int raw_rows [PHASES];
      int phase_start;
      logic signed [SCORE_W-1:0] sc;
      raw_cols = '{6, 1, 16, 0, 31, 3};
      raw_rows = '{6, 1, 16, 31, 0, 12};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ties among column maxima, flat rows
      for (int s = 0; s < 12; s++) begin
         sc = (s == 0) ? SCORE_MIN : (s == 1 || s == 2) ? SCORE_MAX : '0;
         send_item(STIM_W'(s), sc, 1'b1, s == 11, 4'd1, 4'd0);
      end
      // columns only, sums carried from the first sequence
      for (int s = 0; s < 6; s++)
         send_item(STIM_W'(s), (s == 5) ? SCORE_MAX : SCORE_MIN, 1'b0, s == 5,
                   4'd15, 4'd15);
      // stimulus outside the matrix closes an empty sequence
      send_item(5'd31, SCORE_MIN, 1'b1, 1'b1, 4'd0, 4'd0);

      for (int p = 0; p < PHASES; p++) begin
         set_matrix(raw_cols[p], raw_rows[p]);
         tx_steady = (p == 1 || p == 4);
         rx_steady <= (p == 2 || p == 4);
         if (p == 2) begin
            sat_burst(1'b1);
            sat_burst(1'b0);
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_letter();
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
